>>> hw/rtl/ufmc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the union-find maze carver.
// No dependencies; used by ufmc_mod and union_find_maze_carver.
package ufmc_pkg;

   localparam int CELL_W        = 10;
   localparam int NUM_W         = 11;
   localparam int DIM_W         = 6;
   localparam int PICK_W        = 32;
   localparam int WALL_W        = 2;
   localparam int DATA_W        = 32;
   localparam int ADDR_W        = 3;
   localparam int MAX_CELLS_DEF = 1024;

   localparam logic [DIM_W-1:0] GRID_LIMIT = 6'd32;
   localparam logic [DIM_W-1:0] GRID_RESET = 6'd32;

   localparam logic [WALL_W-1:0] WALL_NONE  = 2'd0;
   localparam logic [WALL_W-1:0] WALL_RIGHT = 2'd1;
   localparam logic [WALL_W-1:0] WALL_DOWN  = 2'd2;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   localparam logic REG_COLS = 1'b0;
   localparam logic REG_ROWS = 1'b1;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_GEOM      = 12'b0000_0000_0010,
      ST_CLEAR     = 12'b0000_0000_0100,
      ST_QDIV      = 12'b0000_0000_1000,
      ST_LIST_RD   = 12'b0000_0001_0000,
      ST_LIST_WAIT = 12'b0000_0010_0000,
      ST_CDIV      = 12'b0000_0100_0000,
      ST_FIND_RD   = 12'b0000_1000_0000,
      ST_FIND_CHK  = 12'b0001_0000_0000,
      ST_DECIDE    = 12'b0010_0000_0000,
      ST_SHIFT     = 12'b0100_0000_0000,
      ST_RESP      = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      PH_SELF  = 3'b001,
      PH_RIGHT = 3'b010,
      PH_DOWN  = 3'b100
   } phase_type;

   typedef struct packed {
      logic               start;
      logic [PICK_W-1:0]  dividend;
      logic [NUM_W-1:0]   divisor;
   } div_req_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = 6'd1;
      else if (v > GRID_LIMIT) r = GRID_LIMIT;
      return r;
   endfunction

endpackage

>>> hw/rtl/ufmc_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Uses no package; instantiated by union_find_maze_carver.
module ufmc_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/ufmc_mod.sv
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: 32-bit dividend by NUM_W-bit divisor.
// Depends on ufmc_pkg; one quotient bit per cycle, done pulses after 32 steps.
module ufmc_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  ufmc_pkg::div_req_type      div_req,
   output logic                       div_done,
   output logic [ufmc_pkg::NUM_W-1:0] div_rem
);

   localparam int NW = ufmc_pkg::NUM_W;
   localparam int PW = ufmc_pkg::PICK_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dvs_ff, dvs_in;
   logic [NW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[PW-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = NW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[NW-1:0];
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_done = done_ff;
   assign div_rem  = rem_ff;

endmodule

>>> hw/rtl/union_find_maze_carver.sv
`timescale 1ns / 1ps
// Union-find maze carver top level; uses ufmc_pkg, ufmc_ram, ufmc_mod.
// Start: geometry clamp (rows shrink until the grid fits), then a sweep of both memories.
// Step (skipped to the response once the list is empty): two remainder passes (pick by
// list count, then cell by cols), a root walk per parent hop for the cell and each neighbour,
// then a shift of the list entries on removal. One transaction in flight; the result
// register lets the next start early. Reset sweeps both memories with req_stall high.
module union_find_maze_carver #(
   parameter int MAX_CELLS = ufmc_pkg::MAX_CELLS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic [ufmc_pkg::PICK_W-1:0] req_pick_value,
   input  logic                        req_coin,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ufmc_pkg::CELL_W-1:0] rsp_cell_index,
   output logic [ufmc_pkg::WALL_W-1:0] rsp_wall_knocked,
   output logic                        rsp_maze_done,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ufmc_pkg::ADDR_W-1:0] paddr,
   input  logic [ufmc_pkg::DATA_W-1:0] pwdata,
   output logic [ufmc_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);

   localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int PW = AW + 1;
   localparam int NW = ufmc_pkg::NUM_W;
   localparam int CW = ufmc_pkg::CELL_W;
   localparam int DW = ufmc_pkg::DIM_W;
   localparam int XW = ufmc_pkg::DATA_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CELLS - 1);

   ufmc_pkg::state_type state_ff, state_in;
   ufmc_pkg::phase_type phase_ff, phase_in;

   logic [DW-1:0] cfg_cols_ff, cfg_cols_in;
   logic [DW-1:0] cfg_rows_ff, cfg_rows_in;
   logic [DW-1:0] cols_ff, cols_in;
   logic [DW-1:0] rows_ff, rows_in;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] pos_ff, pos_in;
   logic [NW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] sh_wa_ff, sh_wa_in;
   logic          sh_vld_ff, sh_vld_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rst_sweep_ff, rst_sweep_in;
   logic          type_ff, type_in;
   logic [ufmc_pkg::PICK_W-1:0] pick_ff, pick_in;
   logic          coin_ff, coin_in;
   logic [CW-1:0] v_ff, v_in;
   logic          right_ok_ff, right_ok_in;
   logic          down_ok_ff, down_ok_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] root_v_ff, root_v_in;
   logic [AW-1:0] root_r_ff, root_r_in;
   logic [AW-1:0] root_d_ff, root_d_in;
   logic [CW-1:0] res_cell_ff, res_cell_in;
   logic [ufmc_pkg::WALL_W-1:0] res_wall_ff, res_wall_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_cell_ff, rsp_cell_in;
   logic [ufmc_pkg::WALL_W-1:0] rsp_wall_ff, rsp_wall_in;
   logic          rsp_done_ff, rsp_done_in;

   logic          par_we;
   logic [AW-1:0] par_waddr;
   logic [PW-1:0] par_wdata;
   logic [PW-1:0] par_rdata;
   logic          lst_we;
   logic [AW-1:0] lst_waddr;
   logic [CW-1:0] lst_wdata;
   logic [AW-1:0] lst_raddr;
   logic [CW-1:0] lst_rdata;

   ufmc_pkg::div_req_type div_req;
   logic          div_done;
   logic [NW-1:0] div_rem;

   logic          accept;
   logic          cfg_wr;
   logic [11:0]   prod;
   logic [NW-1:0] v_p1;
   logic [NW-1:0] v_pc;
   logic          right_free;
   logic          down_free;
   logic [DW-1:0] col_clamp;

   ufmc_ram #(.WIDTH(PW), .DEPTH(MAX_CELLS), .AW(AW)) u_parent (
      .clock (clock),
      .we    (par_we),
      .waddr (par_waddr),
      .wdata (par_wdata),
      .raddr (cur_ff),
      .rdata (par_rdata)
   );

   ufmc_ram #(.WIDTH(CW), .DEPTH(MAX_CELLS), .AW(AW)) u_list (
      .clock (clock),
      .we    (lst_we),
      .waddr (lst_waddr),
      .wdata (lst_wdata),
      .raddr (lst_raddr),
      .rdata (lst_rdata)
   );

   ufmc_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_rem  (div_rem)
   );

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;
   assign prdata = (paddr[2] == ufmc_pkg::REG_ROWS) ? XW'(cfg_rows_ff) : XW'(cfg_cols_ff);

   always_comb begin
      cfg_cols_in = cfg_cols_ff;
      cfg_rows_in = cfg_rows_ff;
      if (cfg_wr) begin
         if (paddr[2] == ufmc_pkg::REG_COLS) cfg_cols_in = pwdata[DW-1:0];
         else cfg_rows_in = pwdata[DW-1:0];
      end
   end

   assign req_stall = (state_ff != ufmc_pkg::ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   assign prod       = cols_ff * rows_ff;
   assign v_p1       = {1'b0, v_ff} + NW'(1);
   assign v_pc       = {1'b0, v_ff} + NW'(cols_ff);
   assign right_free = right_ok_ff && (root_r_ff != root_v_ff);
   assign down_free  = down_ok_ff && (root_d_ff != root_v_ff);
   assign col_clamp  = (32'(ufmc_pkg::clamp_dim(cfg_cols_ff)) > 32'(MAX_CELLS)) ?
                       DW'(MAX_CELLS) : ufmc_pkg::clamp_dim(cfg_cols_ff);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      rd_ptr_in    = rd_ptr_ff;
      sh_wa_in     = sh_wa_ff;
      sh_vld_in    = sh_vld_ff;
      clr_in       = clr_ff;
      rst_sweep_in = rst_sweep_ff;
      type_in      = type_ff;
      pick_in      = pick_ff;
      coin_in      = coin_ff;
      v_in         = v_ff;
      right_ok_in  = right_ok_ff;
      down_ok_in   = down_ok_ff;
      cur_in       = cur_ff;
      root_v_in    = root_v_ff;
      root_r_in    = root_r_ff;
      root_d_in    = root_d_ff;
      res_cell_in  = res_cell_ff;
      res_wall_in  = res_wall_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      rsp_wall_in  = rsp_wall_ff;
      rsp_done_in  = rsp_done_ff;
      par_we       = 1'b0;
      par_waddr    = clr_ff;
      par_wdata    = {1'b1, {AW{1'b0}}};
      lst_we       = 1'b0;
      lst_waddr    = clr_ff;
      lst_wdata    = CW'(clr_ff);
      lst_raddr    = AW'(pos_ff);
      div_req          = '0;
      div_req.dividend = pick_ff;
      div_req.divisor  = count_ff;

      case (state_ff)
         ufmc_pkg::ST_IDLE: begin
            if (accept) begin
               type_in  = req_type;
               pick_in  = req_pick_value;
               coin_in  = req_coin;
               cols_in  = col_clamp;
               rows_in  = ufmc_pkg::clamp_dim(cfg_rows_ff);
               state_in = ufmc_pkg::ST_GEOM;
            end
         end
         ufmc_pkg::ST_GEOM: begin
            // shrink rows until the grid fits the store
            if (32'(prod) > 32'(MAX_CELLS)) begin
               rows_in = rows_ff - DW'(1);
            end else begin
               n_in = prod[NW-1:0];
               res_cell_in = '0;
               res_wall_in = ufmc_pkg::WALL_NONE;
               if (type_ff == ufmc_pkg::REQ_START) begin
                  clr_in   = '0;
                  state_in = ufmc_pkg::ST_CLEAR;
               end else if (count_ff == '0) begin
                  state_in = ufmc_pkg::ST_RESP;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ufmc_pkg::ST_QDIV;
               end
            end
         end
         ufmc_pkg::ST_CLEAR: begin
            par_we = 1'b1;
            lst_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               if (rst_sweep_ff) begin
                  rst_sweep_in = 1'b0;
                  count_in     = '0;
                  state_in     = ufmc_pkg::ST_IDLE;
               end else begin
                  count_in = n_ff - NW'(1);
                  state_in = ufmc_pkg::ST_RESP;
               end
            end
         end
         ufmc_pkg::ST_QDIV: begin
            if (div_done) begin
               pos_in   = div_rem;
               state_in = ufmc_pkg::ST_LIST_RD;
            end
         end
         ufmc_pkg::ST_LIST_RD: begin
            state_in = ufmc_pkg::ST_LIST_WAIT;
         end
         ufmc_pkg::ST_LIST_WAIT: begin
            v_in             = lst_rdata;
            div_req.start    = 1'b1;
            div_req.dividend = 32'(lst_rdata);
            div_req.divisor  = NW'(cols_ff);
            state_in         = ufmc_pkg::ST_CDIV;
         end
         ufmc_pkg::ST_CDIV: begin
            if (div_done) begin
               right_ok_in = (div_rem != NW'(cols_ff - DW'(1))) && (v_p1 < n_ff);
               down_ok_in  = (v_pc < n_ff);
               cur_in      = AW'(v_ff);
               phase_in    = ufmc_pkg::PH_SELF;
               state_in    = ufmc_pkg::ST_FIND_RD;
            end
         end
         ufmc_pkg::ST_FIND_RD: begin
            state_in = ufmc_pkg::ST_FIND_CHK;
         end
         ufmc_pkg::ST_FIND_CHK: begin
            if (!par_rdata[AW]) begin
               cur_in   = par_rdata[AW-1:0];
               state_in = ufmc_pkg::ST_FIND_RD;
            end else begin
               case (phase_ff)
                  ufmc_pkg::PH_SELF: begin
                     root_v_in = cur_ff;
                     if (right_ok_ff) begin
                        cur_in   = AW'(v_p1);
                        phase_in = ufmc_pkg::PH_RIGHT;
                        state_in = ufmc_pkg::ST_FIND_RD;
                     end else if (down_ok_ff) begin
                        cur_in   = AW'(v_pc);
                        phase_in = ufmc_pkg::PH_DOWN;
                        state_in = ufmc_pkg::ST_FIND_RD;
                     end else begin
                        state_in = ufmc_pkg::ST_DECIDE;
                     end
                  end
                  ufmc_pkg::PH_RIGHT: begin
                     root_r_in = cur_ff;
                     if (down_ok_ff) begin
                        cur_in   = AW'(v_pc);
                        phase_in = ufmc_pkg::PH_DOWN;
                        state_in = ufmc_pkg::ST_FIND_RD;
                     end else begin
                        state_in = ufmc_pkg::ST_DECIDE;
                     end
                  end
                  default: begin
                     root_d_in = cur_ff;
                     state_in  = ufmc_pkg::ST_DECIDE;
                  end
               endcase
            end
         end
         ufmc_pkg::ST_DECIDE: begin
            res_cell_in = v_ff;
            res_wall_in = ufmc_pkg::WALL_NONE;
            par_wdata   = {1'b0, AW'(v_ff)};
            if (right_free && down_free) begin
               par_we = 1'b1;
               if (!coin_ff) begin
                  par_waddr   = root_r_ff;
                  res_wall_in = ufmc_pkg::WALL_RIGHT;
               end else begin
                  par_waddr   = root_d_ff;
                  res_wall_in = ufmc_pkg::WALL_DOWN;
               end
               state_in = ufmc_pkg::ST_RESP;
            end else begin
               if (right_free) begin
                  par_we      = 1'b1;
                  par_waddr   = root_r_ff;
                  res_wall_in = ufmc_pkg::WALL_RIGHT;
               end else if (down_free) begin
                  par_we      = 1'b1;
                  par_waddr   = root_d_ff;
                  res_wall_in = ufmc_pkg::WALL_DOWN;
               end
               rd_ptr_in = pos_ff + NW'(1);
               sh_vld_in = 1'b0;
               state_in  = ufmc_pkg::ST_SHIFT;
            end
         end
         ufmc_pkg::ST_SHIFT: begin
            // stream entries one slot down: read ahead, write the previous read
            lst_raddr = AW'(rd_ptr_ff);
            lst_waddr = AW'(sh_wa_ff);
            lst_wdata = lst_rdata;
            lst_we    = sh_vld_ff;
            if (rd_ptr_ff < count_ff) begin
               sh_vld_in = 1'b1;
               sh_wa_in  = rd_ptr_ff - NW'(1);
               rd_ptr_in = rd_ptr_ff + NW'(1);
            end else begin
               sh_vld_in = 1'b0;
               if (!sh_vld_ff) begin
                  count_in = count_ff - NW'(1);
                  state_in = ufmc_pkg::ST_RESP;
               end
            end
         end
         ufmc_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = res_cell_ff;
               rsp_wall_in  = res_wall_ff;
               rsp_done_in  = (count_ff == '0);
               state_in     = ufmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ufmc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufmc_pkg::ST_CLEAR;
         phase_ff     <= ufmc_pkg::PH_SELF;
         clr_ff       <= '0;
         rst_sweep_ff <= 1'b1;
         count_ff     <= '0;
         sh_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_cols_ff  <= ufmc_pkg::GRID_RESET;
         cfg_rows_ff  <= ufmc_pkg::GRID_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
         rst_sweep_ff <= rst_sweep_in;
         count_ff     <= count_in;
         sh_vld_ff    <= sh_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_cols_ff  <= cfg_cols_in;
         cfg_rows_ff  <= cfg_rows_in;
      end
      cols_ff     <= cols_in;
      rows_ff     <= rows_in;
      n_ff        <= n_in;
      pos_ff      <= pos_in;
      rd_ptr_ff   <= rd_ptr_in;
      sh_wa_ff    <= sh_wa_in;
      type_ff     <= type_in;
      pick_ff     <= pick_in;
      coin_ff     <= coin_in;
      v_ff        <= v_in;
      right_ok_ff <= right_ok_in;
      down_ok_ff  <= down_ok_in;
      cur_ff      <= cur_in;
      root_v_ff   <= root_v_in;
      root_r_ff   <= root_r_in;
      root_d_ff   <= root_d_in;
      res_cell_ff <= res_cell_in;
      res_wall_ff <= res_wall_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_wall_ff <= rsp_wall_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_index   = rsp_cell_ff;
   assign rsp_wall_knocked = rsp_wall_ff;
   assign rsp_maze_done    = rsp_done_ff;

endmodule
